/* rtl/sbrd_pkg.sv */
// ----------------------------------------------------------------------------
// sbrd_pkg
// shared widths, register map and reset values of the bin rise detector
// ----------------------------------------------------------------------------
package sbrd_pkg;

  localparam int unsigned IDX_W    = 8;
  localparam int unsigned PWR_W    = 8;
  localparam int unsigned STREAK_W = 4;
  localparam int unsigned COUNT_W  = 9;

  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned CFG_DW   = 32;

  typedef logic signed [PWR_W-1:0]    pwr_t;
  typedef logic        [STREAK_W-1:0] streak_t;
  typedef logic        [COUNT_W-1:0]  count_t;

  typedef enum logic [1:0] {
    REG_MISSING_MARKER = 2'd0,
    REG_FLOOR_LEVEL    = 2'd1,
    REG_RISE_STEP      = 2'd2,
    REG_STREAK_NEEDED  = 2'd3
  } reg_idx_t;

  localparam pwr_t               MISSING_RST = -8'sd128;
  localparam pwr_t               FLOOR_RST   = -8'sd65;
  localparam logic [PWR_W-1:0]   STEP_RST    = 8'd12;
  localparam streak_t            NEED_RST    = 4'd3;

  localparam count_t             COUNT_MAX   = '1;

endpackage

/* rtl/sbrd_in_if.sv */
// ----------------------------------------------------------------------------
// sbrd_in_if
// input channel: one bin word per handshake
// ----------------------------------------------------------------------------
interface sbrd_in_if;
  import sbrd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        bin_index;
  logic signed [PWR_W-1:0] base_power;
  logic signed [PWR_W-1:0] now_power;
  logic                    comparable;
  logic                    last_bin;

  modport source (
    output valid, bin_index, base_power, now_power, comparable, last_bin,
    input  ready
  );

  modport sink (
    input  valid, bin_index, base_power, now_power, comparable, last_bin,
    output ready
  );

endinterface

/* rtl/sbrd_out_if.sv */
// ----------------------------------------------------------------------------
// sbrd_out_if
// result channel: one result word per handshake
// ----------------------------------------------------------------------------
interface sbrd_out_if;
  import sbrd_pkg::*;

  logic               valid;
  logic               ready;
  logic               bin_changed;
  logic [COUNT_W-1:0] changed_count;
  logic               pass_done;

  modport source (
    output valid, bin_changed, changed_count, pass_done,
    input  ready
  );

  modport sink (
    input  valid, bin_changed, changed_count, pass_done,
    output ready
  );

endinterface

/* rtl/spectrum_bin_rise_detector_unit.sv */
// ----------------------------------------------------------------------------
// spectrum_bin_rise_detector_unit
// per-bin rise persistence tracker with a running changed-bin count per pass
// ----------------------------------------------------------------------------
// One bin word is accepted each cycle unless the output stalls; its result
// passes the compare stage and the output register. Per-bin streak counters
// live in a single memory with a registered read; a counter is read when its
// word is accepted and written back as it leaves the compare stage; the last
// write is forwarded so the same bin may arrive on consecutive cycles. Streak
// entries start at zero through per-entry valid bits cleared by reset, so no
// clearing pass is needed and words are accepted from the first cycle after
// reset. Bins at or above MAX_BINS update no counter and report unchanged.
// ----------------------------------------------------------------------------
module spectrum_bin_rise_detector_unit #(
  parameter int unsigned MAX_BINS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sbrd_in_if.sink                      in_ch,
  sbrd_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sbrd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [sbrd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [sbrd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import sbrd_pkg::*;

  localparam int unsigned DEPTH = (MAX_BINS < (1 << IDX_W)) ? MAX_BINS : (1 << IDX_W);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  pwr_t             missing_r;
  pwr_t             floor_r;
  logic [PWR_W-1:0] step_r;
  streak_t          need_r;

  // streak memory and entry valid bits
  streak_t          mem [DEPTH];
  logic [DEPTH-1:0] vbit_r;
  streak_t          rd_data_r;
  logic             rd_vld_r;

  // last write-back for forwarding
  logic             wb_vld_r;
  logic [AW-1:0]    wb_addr_r;
  streak_t          wb_data_r;

  // compare stage
  logic             s1_valid_r;
  logic [AW-1:0]    s1_addr_r;
  logic             s1_inrange_r;
  pwr_t             s1_base_r;
  pwr_t             s1_now_r;
  logic             s1_comp_r;
  logic             s1_last_r;

  count_t           pass_changed_r;

  // output word
  logic             out_valid_r;
  logic             out_changed_r;
  count_t           out_count_r;
  logic             out_done_r;

  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  logic             in_fire;
  logic             out_take;
  logic             s1_fire;
  logic [AW-1:0]    in_addr;
  logic             in_inrange;
  streak_t          cur_streak;
  logic signed [PWR_W+1:0] diff;
  logic             rise;
  streak_t          streak_nxt;
  logic             changed;
  count_t           count_nxt;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_MISSING_MARKER: cfg_prdata = CFG_DW'({missing_r});
      REG_FLOOR_LEVEL:    cfg_prdata = CFG_DW'({floor_r});
      REG_RISE_STEP:      cfg_prdata = CFG_DW'(step_r);
      REG_STREAK_NEEDED:  cfg_prdata = CFG_DW'(need_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      missing_r <= MISSING_RST;
      floor_r   <= FLOOR_RST;
      step_r    <= STEP_RST;
      need_r    <= NEED_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MISSING_MARKER: missing_r <= pwr_t'(cfg_pwdata[PWR_W-1:0]);
        REG_FLOOR_LEVEL:    floor_r   <= pwr_t'(cfg_pwdata[PWR_W-1:0]);
        REG_RISE_STEP:      step_r    <= cfg_pwdata[PWR_W-1:0];
        REG_STREAK_NEEDED:  need_r    <= cfg_pwdata[STREAK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshakes
  assign out_take     = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && out_take;
  assign in_ch.ready  = !s1_valid_r || out_take;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_addr      = in_ch.bin_index[AW-1:0];
  assign in_inrange   = 32'(in_ch.bin_index) < 32'(MAX_BINS);

  // rise test and streak update
  assign cur_streak = (wb_vld_r && (wb_addr_r == s1_addr_r)) ? wb_data_r :
                      (rd_vld_r ? rd_data_r : '0);
  assign diff = (PWR_W+2)'(s1_now_r) - (PWR_W+2)'(s1_base_r);
  assign rise = s1_comp_r && (s1_base_r != missing_r) && (s1_now_r != missing_r) &&
                (s1_now_r >= floor_r) && (diff >= $signed({2'b00, step_r}));

  always_comb begin
    if (!rise) begin
      streak_nxt = '0;
    end else if (cur_streak < need_r) begin
      streak_nxt = cur_streak + STREAK_W'(1);
    end else begin
      streak_nxt = cur_streak;
    end
  end

  assign changed   = s1_inrange_r && (streak_nxt >= need_r);
  assign count_nxt = (changed && (pass_changed_r != COUNT_MAX)) ?
                     pass_changed_r + COUNT_W'(1) : pass_changed_r;

  // streak memory
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= mem[in_addr];
    end
    if (s1_fire && s1_inrange_r) begin
      mem[s1_addr_r] <= streak_nxt;
    end
  end

  // payload of the compare stage, the output word and the last write-back
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r    <= in_addr;
      s1_inrange_r <= in_inrange;
      s1_base_r    <= in_ch.base_power;
      s1_now_r     <= in_ch.now_power;
      s1_comp_r    <= in_ch.comparable;
      s1_last_r    <= in_ch.last_bin;
    end
    if (s1_fire) begin
      out_changed_r <= changed;
      out_count_r   <= count_nxt;
      out_done_r    <= s1_last_r;
    end
    if (s1_fire && s1_inrange_r) begin
      wb_addr_r <= s1_addr_r;
      wb_data_r <= streak_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbit_r         <= '0;
      rd_vld_r       <= 1'b0;
      wb_vld_r       <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      pass_changed_r <= '0;
    end else begin
      if (in_fire) begin
        rd_vld_r <= vbit_r[in_addr];
      end
      if (s1_fire && s1_inrange_r) begin
        vbit_r[s1_addr_r] <= 1'b1;
        wb_vld_r          <= 1'b1;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r    <= 1'b1;
        pass_changed_r <= s1_last_r ? '0 : count_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.bin_changed   = out_changed_r;
  assign out_ch.changed_count = out_count_r;
  assign out_ch.pass_done     = out_done_r;

  // checks
  a_pass_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> pass_changed_r == '0)
    else $error("pass count not cleared after last bin");

  a_changed_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_changed_r |-> out_count_r != '0)
    else $error("changed bin word with zero count");

  a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> $stable(cur_streak) && $stable(s1_addr_r))
    else $error("read data lost while stalled");

  a_unchanged_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_inrange_r |=> !out_changed_r)
    else $error("out-of-range bin reported changed");

endmodule
